/* hdl/mrlr_pkg.sv */
package mrlr_pkg;

  // Result codes with a meaning of their own in the decision logic.
  localparam logic [4:0] CODE_NONE        = 5'd0;
  localparam logic [4:0] CODE_CONNECT     = 5'd10;
  localparam logic [4:0] CODE_FAX_CONNECT = 5'd12;

  // Word list layout.
  localparam int WORD_COUNT      = 24;
  localparam int WORD_CHARS      = 11;
  localparam int BIT_CONNECT_FAX = 21;
  localparam int BIT_CONNECT     = 22;
  localparam int BIT_CARRIER     = 23;
  localparam int SPEED_POS       = 7;

  typedef logic [WORD_CHARS*8-1:0] word_text_t;
  typedef logic [WORD_COUNT-1:0]   word_mask_t;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

  localparam logic [31:0] DEFAULT_SPEED = 32'd300;
  localparam logic [31:0] MAG_LIMIT     = 32'h8000_0000;
  localparam logic [31:0] POS_MAX       = 32'h7FFF_FFFF;

  // Word texts, right-aligned: the last character sits in the lowest byte.
  localparam word_text_t WORD_TEXT [WORD_COUNT] = '{
    "+FHS:", "+FCO:", "+FPO", "+FVO", "+FIS:", "+FNF:", "+FCI:", "+FPS:",
    "+FCS:", "+FNS:", "+FTI:", "+FET:", "OK", "BUSY", "ERROR", "NO ANSWER",
    "NO CARRIER", "NO DIALTONE", "RING", "RINGING", "VOICE", "CONNECT FAX",
    "CONNECT", "CARRIER"
  };

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd5, 4'd5, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd2, 4'd4, 4'd5, 4'd9,
    4'd10, 4'd11, 4'd4, 4'd7, 4'd5, 4'd11, 4'd7, 4'd7
  };

  localparam logic [4:0] WORD_CODE [WORD_COUNT] = '{
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd1, 5'd2, 5'd3, 5'd4,
    5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd12, 5'd10, 5'd10
  };

  // Bit k set: word k matches as a prefix, or ignores letter case.
  localparam word_mask_t WORD_PREFIX = 24'hC00FFF;
  localparam word_mask_t WORD_FOLD   = 24'hFFF000;

  // Character at position idx (idx below the word's length) of word k.
  function automatic logic [7:0] word_byte(input int k, input logic [3:0] idx);
    logic [3:0] sel;
    sel = WORD_LEN[k] - 4'd1 - idx;
    return WORD_TEXT[k][{sel, 3'b000} +: 8];
  endfunction

  // ASCII lower case to upper case; other bytes pass unchanged.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? (c & 8'hDF) : c;
  endfunction

endpackage

/* hdl/modem_result_line_recognizer_core.sv */
// Modem result line recogniser.
// The input channel (in_valid, in_ready, in_rx_byte) takes one received modem
// byte per transfer. A carriage return closes the line and causes exactly one
// transfer on the result channel (out_valid, out_ready, out_result_code,
// out_line_speed); all other bytes cause none. Line feeds are dropped and
// characters past LINE_BYTES-1 in a line are ignored.
// Each byte is decoded in the cycle of its transfer: match flags and the
// decimal speed accumulator update at that clock edge, so one byte is taken
// every cycle while in_ready is high. The result of a carriage return appears
// in the output register in the cycle after its transfer.
// The output register acts as the skid stage: while a result waits, in_ready
// stays high only if out_ready is high, so a stalled receiver holds the input
// side for as long as the result is not taken; no result is ever dropped.
// Reset (rst_n low at a clock edge) empties the output register and starts a
// fresh line with all words as candidates.
module modem_result_line_recognizer_core
  import mrlr_pkg::*;
#(
  parameter int LINE_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_result_code,
  output logic signed [31:0] out_line_speed
);

  localparam int PW = $clog2(LINE_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(LINE_BYTES - 1);
  localparam logic [PW-1:0] SPD_POS  = PW'(SPEED_POS);

  // Number parser phases.
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  logic [PW-1:0] pos_r, pos_nxt;
  word_mask_t    cand_r, cand_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          neg_r, neg_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [4:0]    code_r, code_nxt;
  logic [31:0]   speed_r, speed_nxt;

  logic          accept;
  logic          is_digit;
  logic [3:0]    digit;
  logic [35:0]   prod;
  logic [7:0]    pos_w;
  word_mask_t    len_gt_pos;
  word_mask_t    cand_end;
  word_mask_t    cand_take;
  logic [31:0]   end_acc;
  logic          end_neg;
  logic [31:0]   mag;
  logic [31:0]   signed_speed;
  logic [4:0]    first_code;
  logic [7:0]    x;

  assign in_ready        = !out_valid_r || out_ready;
  assign accept          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_result_code = code_r;
  assign out_line_speed  = $signed(speed_r);

  assign is_digit = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
  assign digit    = in_rx_byte[3:0];
  assign pos_w    = 8'(pos_r);

  // Candidate flags: the end-of-text pruning and the per-character match.
  always_comb begin
    len_gt_pos = '0;
    cand_take  = '0;
    for (int k = 0; k < WORD_COUNT; k++) begin
      len_gt_pos[k] = 8'(WORD_LEN[k]) > pos_w;
      x = WORD_FOLD[k] ? fold_upper(in_rx_byte) : in_rx_byte;
      if (len_gt_pos[k]) begin
        cand_take[k] = cand_r[k] && (x == word_byte(k, pos_w[3:0]));
      end else begin
        cand_take[k] = cand_r[k] && WORD_PREFIX[k];
      end
    end
    cand_end = cand_r & ~len_gt_pos;
  end

  // Speed as it stands when the text ends here, then its signed form.
  always_comb begin
    end_acc = (pos_r == SPD_POS) ? DEFAULT_SPEED : acc_r;
    end_neg = (pos_r == SPD_POS) ? 1'b0 : neg_r;
    mag     = (end_acc > MAG_LIMIT) ? MAG_LIMIT : end_acc;
    if (end_neg) begin
      signed_speed = 32'd0 - mag;
    end else begin
      signed_speed = mag[31] ? POS_MAX : mag;
    end
  end

  // First remaining plain word, in list order.
  always_comb begin
    first_code = CODE_NONE;
    for (int k = BIT_CONNECT_FAX - 1; k >= 0; k--) begin
      if (cand_end[k]) begin
        first_code = WORD_CODE[k];
      end
    end
  end

  // Accumulator times ten plus the new digit.
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, digit};

  // Line state and result register updates.
  always_comb begin
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    acc_nxt       = acc_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    code_nxt      = code_r;
    speed_nxt     = speed_r;

    if (accept) begin
      if (in_rx_byte == CHAR_CR) begin
        out_valid_nxt = 1'b1;
        if (cand_end[BIT_CONNECT_FAX]) begin
          code_nxt  = CODE_FAX_CONNECT;
          speed_nxt = 32'd0;
        end else if (cand_end[BIT_CONNECT] || cand_end[BIT_CARRIER]) begin
          code_nxt  = CODE_CONNECT;
          speed_nxt = signed_speed;
        end else begin
          code_nxt  = first_code;
          speed_nxt = 32'd0;
        end
        pos_nxt   = '0;
        cand_nxt  = '1;
        acc_nxt   = 32'd0;
        phase_nxt = PH_SKIP;
        neg_nxt   = 1'b0;
      end else if (in_rx_byte == CHAR_LF || pos_r >= LAST_POS) begin
        // Dropped: line feed or line already full.
      end else if (in_rx_byte == CHAR_NUL) begin
        // A zero byte ends the text; the rest of the line is ignored.
        cand_nxt = cand_end;
        if (pos_r == SPD_POS) begin
          acc_nxt   = DEFAULT_SPEED;
          neg_nxt   = 1'b0;
          phase_nxt = PH_STOP;
        end
        pos_nxt = LAST_POS;
      end else begin
        cand_nxt = cand_take;
        pos_nxt  = pos_r + {{(PW-1){1'b0}}, 1'b1};
        if (pos_r == SPD_POS) begin
          if (in_rx_byte != CHAR_SPACE) begin
            acc_nxt   = DEFAULT_SPEED;
            neg_nxt   = 1'b0;
            phase_nxt = PH_STOP;
          end
        end else if (pos_r > SPD_POS) begin
          unique case (phase_r) inside
            PH_SKIP: begin
              if (in_rx_byte == CHAR_SPACE || in_rx_byte == CHAR_TAB ||
                  in_rx_byte == CHAR_VT || in_rx_byte == CHAR_FF) begin
                phase_nxt = PH_SKIP;
              end else if (in_rx_byte == CHAR_PLUS || in_rx_byte == CHAR_MINUS) begin
                neg_nxt   = (in_rx_byte == CHAR_MINUS);
                phase_nxt = PH_SIGN;
              end else if (is_digit) begin
                acc_nxt   = {28'd0, digit};
                phase_nxt = PH_DIGIT;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
            PH_SIGN, PH_DIGIT: begin
              if (is_digit) begin
                if (phase_r == PH_SIGN) begin
                  acc_nxt = {28'd0, digit};
                end else if (prod > {4'd0, MAG_LIMIT}) begin
                  acc_nxt = MAG_LIMIT;
                end else begin
                  acc_nxt = prod[31:0];
                end
                phase_nxt = PH_DIGIT;
              end else begin
                phase_nxt = PH_STOP;
              end
            end
            default: begin
              phase_nxt = PH_STOP;
            end
          endcase
        end
      end
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cand_r      <= '1;
      acc_r       <= 32'd0;
      phase_r     <= PH_SKIP;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      cand_r      <= cand_nxt;
      acc_r       <= acc_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    speed_r <= speed_nxt;
  end

endmodule

/* bench/modem_result_line_recognizer_core_tb.sv */
`timescale 1ns / 100ps

module modem_result_line_recognizer_core_tb
  import mrlr_pkg::*;
;

  localparam int LINE_BYTES     = 128;
  localparam int N_WORDS        = 24;
  localparam int IDX_CONNECT_FAX = 21;
  localparam int IDX_CONNECT    = 22;
  localparam int IDX_CARRIER    = 23;
  localparam int SPEED_CHAR_POS = 7;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 145;

  localparam logic [31:0] SPEED_DEFAULT = 32'd300;
  localparam logic [31:0] SAT_MAG       = 32'h8000_0000;

  // Word flags: prefix match allowed, letter case ignored.
  localparam logic [N_WORDS-1:0] PREFIX_WORDS   = 24'hC00FFF;
  localparam logic [N_WORDS-1:0] CASELESS_WORDS = 24'hFFF000;

  typedef enum logic [4:0] {
    RC_NONE, RC_OK, RC_BUSY, RC_ERROR, RC_NO_ANSWER, RC_NO_CARRIER,
    RC_NO_DIALTONE, RC_RING, RC_RINGING, RC_VOICE, RC_CONNECT,
    RC_FHS, RC_FCO, RC_FPO, RC_FVO, RC_FIS, RC_FNF, RC_FCI, RC_FPS,
    RC_FCS, RC_FNS, RC_FTI, RC_FET
  } result_code_t;

  typedef enum logic [1:0] {NUM_SKIP, NUM_SIGN, NUM_DIGITS, NUM_STOP} num_phase_t;

  typedef struct packed {
    logic [4:0]         code;
    logic signed [31:0] speed;
  } line_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         out_result_code;
  logic signed [31:0] out_line_speed;

  modem_result_line_recognizer_core #(
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_code(out_result_code),
    .out_line_speed (out_line_speed)
  );

  // Word table used by the line decoder and by the stimulus.
  string        word_txt [N_WORDS];
  result_code_t word_rc  [N_WORDS];

  // Bytes waiting to be offered and line results waiting to come out.
  logic [7:0]   pending_bytes [$];
  line_result_t waiting_results [$];

  // Flow control, set by the stimulus; stall_seen/stall_left by the receiver.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit stall_req = 1'b0;
  bit stall_seen = 1'b0;
  int stall_left = 0;
  bit lf_noise = 1'b0;

  int bytes_queued = 0;
  int bytes_taken = 0;
  int lines_queued = 0;
  int results_checked = 0;
  int connect_results = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // Line decoder state.
  logic [7:0]         pos_in_line = 8'd0;
  logic [N_WORDS-1:0] still_matching = '1;
  logic [31:0]        speed_mag = 32'd0;
  num_phase_t         num_state = NUM_SKIP;
  logic               speed_neg = 1'b0;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ? c - 8'd32 : c;
  endfunction

  function automatic void start_line();
    pos_in_line    = 8'd0;
    still_matching = '1;
    speed_mag      = 32'd0;
    num_state      = NUM_SKIP;
    speed_neg      = 1'b0;
  endfunction

  // End of the text at position p: words longer than the text drop out, and a
  // line that ends right after CONNECT or CARRIER takes the default speed.
  function automatic void stop_text(input int p);
    for (int k = 0; k < N_WORDS; k++)
      if (word_txt[k].len() > p) still_matching[k] = 1'b0;
    if (p == SPEED_CHAR_POS) begin
      speed_mag = SPEED_DEFAULT;
      speed_neg = 1'b0;
      num_state = NUM_STOP;
    end
  endfunction

  // One character at position p: narrow the candidates, then advance the
  // speed parser for characters after CONNECT or CARRIER.
  function automatic void take_char(input logic [7:0] c, input int p);
    logic [7:0]  x;
    logic [63:0] v;
    for (int k = 0; k < N_WORDS; k++) begin
      if (still_matching[k]) begin
        if (p < word_txt[k].len()) begin
          x = CASELESS_WORDS[k] ? upcase(c) : c;
          if (x != 8'(word_txt[k][p])) still_matching[k] = 1'b0;
        end else if (!PREFIX_WORDS[k]) begin
          still_matching[k] = 1'b0;
        end
      end
    end
    if (p == SPEED_CHAR_POS) begin
      if (c != CHAR_SPACE) begin
        speed_mag = SPEED_DEFAULT;
        speed_neg = 1'b0;
        num_state = NUM_STOP;
      end
    end else if (p > SPEED_CHAR_POS) begin
      case (num_state) inside
        NUM_SKIP: begin
          if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) begin
            num_state = NUM_SKIP;
          end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            speed_neg = (c == CHAR_MINUS);
            num_state = NUM_SIGN;
          end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            speed_mag = 32'(c - CHAR_ZERO);
            num_state = NUM_DIGITS;
          end else begin
            num_state = NUM_STOP;
          end
        end
        NUM_SIGN, NUM_DIGITS: begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = (num_state == NUM_DIGITS) ? {32'd0, speed_mag} * 64'd10 : 64'd0;
            v = v + 64'(c - CHAR_ZERO);
            speed_mag = (v > 64'(SAT_MAG)) ? SAT_MAG : v[31:0];
            num_state = NUM_DIGITS;
          end else begin
            num_state = NUM_STOP;
          end
        end
        default: num_state = NUM_STOP;
      endcase
    end
  endfunction

  // Decode one accepted byte; a carriage return closes the line with a result.
  function automatic bit decode_byte(input logic [7:0] c, output line_result_t res);
    logic [31:0] mag;
    res.code  = RC_NONE;
    res.speed = 32'sd0;
    if (c == CHAR_CR) begin
      stop_text(int'(pos_in_line));
      if (still_matching[IDX_CONNECT_FAX]) begin
        res.code = RC_FCO;
      end else if (still_matching[IDX_CONNECT] || still_matching[IDX_CARRIER]) begin
        res.code = RC_CONNECT;
        mag = (speed_mag > SAT_MAG) ? SAT_MAG : speed_mag;
        if (speed_neg) res.speed = 32'd0 - mag;
        else res.speed = (mag == SAT_MAG) ? SAT_MAG - 32'd1 : mag;
      end else begin
        for (int k = N_WORDS - 1; k >= 0; k--)
          if (still_matching[k]) res.code = word_rc[k];
      end
      start_line();
      return 1'b1;
    end
    if (c != CHAR_LF && int'(pos_in_line) < LINE_BYTES - 1) begin
      if (c == CHAR_NUL) begin
        stop_text(int'(pos_in_line));
        pos_in_line = 8'(LINE_BYTES - 1);
      end else begin
        take_char(c, int'(pos_in_line));
        pos_in_line = pos_in_line + 8'd1;
      end
    end
    return 1'b0;
  endfunction

  // Queue one byte, now and then preceded by a stray line feed.
  task automatic put(input logic [7:0] b);
    if (lf_noise && $urandom_range(99) < 5) pending_bytes.push_back(CHAR_LF);
    pending_bytes.push_back(b);
    bytes_queued++;
    if (b == CHAR_CR) lines_queued++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(8'(s[i]));
  endtask

  // Speed field after CONNECT or CARRIER: none, a non-space character, or a
  // space followed by blanks, a sign, digits and trailing junk.
  task automatic speed_tail();
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      r = r;
    end else if (r < 20) begin
      put(8'($urandom_range(33, 126)));
      repeat ($urandom_range(0, 4)) put(8'($urandom_range(32, 126)));
    end else begin
      put(CHAR_SPACE);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(3))
          0: put(CHAR_SPACE);
          1: put(CHAR_TAB);
          2: put(CHAR_VT);
          default: put(CHAR_FF);
        endcase
      end
      case ($urandom_range(2))
        0: put(CHAR_PLUS);
        1: put(CHAR_MINUS);
        default: r = r;
      endcase
      if (r < 30) put_text($urandom_range(1) ? "2147483647" : "2147483648");
      else repeat ($urandom_range(0, 12)) put(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
      if ($urandom_range(1)) put_text("/ARQ");
      else repeat ($urandom_range(0, 3)) put(8'($urandom_range(32, 126)));
    end
  endtask

  // A line built on word w: exact, with a tail, cut short, with one wrong
  // character, split by a zero byte, or in mixed case.
  task automatic word_line(input int w);
    int         v, len, cut, bad_at, tail;
    bit         mix, nul_split;
    logic [7:0] c;
    len       = word_txt[w].len();
    cut       = len;
    bad_at    = -1;
    tail      = 0;
    nul_split = 1'b0;
    mix       = CASELESS_WORDS[w] && $urandom_range(1);
    v         = $urandom_range(99);
    if (v < 15) tail = $urandom_range(1, 6);
    else if (v < 25) cut = $urandom_range(1, len - 1);
    else if (v < 35) bad_at = $urandom_range(0, len - 1);
    else if (v < 45) nul_split = 1'b1;
    else if (v < 52 && !CASELESS_WORDS[w]) mix = 1'b1;
    else if (!CASELESS_WORDS[w] && $urandom_range(1)) tail = $urandom_range(1, 6);
    for (int i = 0; i < cut; i++) begin
      c = 8'(word_txt[w][i]);
      if (i == bad_at) c = 8'($urandom_range(32, 126));
      else if (mix && c >= "A" && c <= "Z" && $urandom_range(1)) c = c + 8'd32;
      put(c);
    end
    if (nul_split) begin
      put(CHAR_NUL);
      tail = $urandom_range(0, 4);
    end
    if ((w == IDX_CONNECT || w == IDX_CARRIER) && v >= 45) speed_tail();
    else repeat (tail) put(8'($urandom_range(32, 126)));
    put(CHAR_CR);
  endtask

  // Random bytes of any value but carriage return, or a line near or past the
  // length limit that starts with a word.
  task automatic noise_line(input bit long_one);
    logic [7:0] b;
    if (long_one) begin
      put_text(word_txt[$urandom_range(N_WORDS - 1)]);
      repeat ($urandom_range(LINE_BYTES - 16, LINE_BYTES + 16))
        put(8'($urandom_range(32, 126)));
    end else begin
      repeat ($urandom_range(0, 16)) begin
        b = 8'($urandom_range(255));
        put(b == CHAR_CR ? 8'hFF : b);
      end
    end
    put(CHAR_CR);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || waiting_results.size() != 0)
      @(negedge clk);
  endtask

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Input driver: offer the next pending byte once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_rx_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold on request.
  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: decode every input transfer, then check every result transfer
  // against the oldest expected line result.
  always @(posedge clk) begin : monitor
    line_result_t res;
    line_result_t want;
    if (!rst_n) begin
      start_line();
    end else begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (decode_byte(in_rx_byte, res)) waiting_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (waiting_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual code %0d speed %0d",
                   $time, out_result_code, out_line_speed);
          errors++;
        end else begin
          want = waiting_results.pop_front();
          results_checked++;
          if (want.code == RC_CONNECT) connect_results++;
          if (out_result_code !== want.code) begin
            $display("%0t: result_code expected %0d, actual %0d",
                     $time, want.code, out_result_code);
            errors++;
          end
          if (out_line_speed !== want.speed) begin
            $display("%0t: line_speed expected %0d, actual %0d",
                     $time, want.speed, out_line_speed);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("modem_result_line_recognizer_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    int target;
    int line_no;
    word_txt[0]  = "+FHS:";       word_rc[0]  = RC_FHS;
    word_txt[1]  = "+FCO:";       word_rc[1]  = RC_FCO;
    word_txt[2]  = "+FPO";        word_rc[2]  = RC_FPO;
    word_txt[3]  = "+FVO";        word_rc[3]  = RC_FVO;
    word_txt[4]  = "+FIS:";       word_rc[4]  = RC_FIS;
    word_txt[5]  = "+FNF:";       word_rc[5]  = RC_FNF;
    word_txt[6]  = "+FCI:";       word_rc[6]  = RC_FCI;
    word_txt[7]  = "+FPS:";       word_rc[7]  = RC_FPS;
    word_txt[8]  = "+FCS:";       word_rc[8]  = RC_FCS;
    word_txt[9]  = "+FNS:";       word_rc[9]  = RC_FNS;
    word_txt[10] = "+FTI:";       word_rc[10] = RC_FTI;
    word_txt[11] = "+FET:";       word_rc[11] = RC_FET;
    word_txt[12] = "OK";          word_rc[12] = RC_OK;
    word_txt[13] = "BUSY";        word_rc[13] = RC_BUSY;
    word_txt[14] = "ERROR";       word_rc[14] = RC_ERROR;
    word_txt[15] = "NO ANSWER";   word_rc[15] = RC_NO_ANSWER;
    word_txt[16] = "NO CARRIER";  word_rc[16] = RC_NO_CARRIER;
    word_txt[17] = "NO DIALTONE"; word_rc[17] = RC_NO_DIALTONE;
    word_txt[18] = "RING";        word_rc[18] = RC_RING;
    word_txt[19] = "RINGING";     word_rc[19] = RC_RINGING;
    word_txt[20] = "VOICE";       word_rc[20] = RC_VOICE;
    word_txt[21] = "CONNECT FAX"; word_rc[21] = RC_FCO;
    word_txt[22] = "CONNECT";     word_rc[22] = RC_CONNECT;
    word_txt[23] = "CARRIER";     word_rc[23] = RC_CONNECT;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines: empty line, a word in mixed case, the default speed,
    // a fax prefix, and the lowest and highest byte with a line feed.
    put(CHAR_CR);
    put_text("Ok");
    put(CHAR_CR);
    put_text("CONNECT");
    put(CHAR_CR);
    put_text("+FPO");
    put(CHAR_CR);
    put(CHAR_NUL);
    put(8'hFF);
    put(CHAR_LF);
    put(CHAR_CR);
    wait_idle();

    // Random lines in four flow-control phases; the first lines sweep every
    // word, and the receiver holds off for a long stretch in the first phase.
    lf_noise = 1'b1;
    line_no  = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          stall_req      = ~stall_req;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      target = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) begin
        if (line_no < N_WORDS) word_line(line_no);
        else if (line_no == N_WORDS + 3 || $urandom_range(99) < 3) noise_line(1'b1);
        else if ($urandom_range(99) < 15) noise_line(1'b0);
        else word_line($urandom_range(N_WORDS - 1));
        line_no++;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (waiting_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, waiting_results.size());
      errors++;
    end
    $display("Run: %0d bytes taken in %0d lines, %0d results checked (%0d with a speed).",
             bytes_taken, lines_queued, results_checked, connect_results);
    $display("Covered every word, speed parsing, long and zero-byte lines, four stall phases.");
    if (errors == 0) begin
      $display("modem_result_line_recognizer_core_tb: PASS");
    end else begin
      $display("modem_result_line_recognizer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
